>>> rtl/global_alignment_engine_assert.svh
// Assertion macros shared by the alignment engine RTL
`ifndef GLOBAL_ALIGNMENT_ENGINE_ASSERT_SVH
`define GLOBAL_ALIGNMENT_ENGINE_ASSERT_SVH
`ifndef SYNTH
`define GAE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GAE_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GAE_ASSERT(lbl, clk, rst, prop, msg)
`define GAE_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

>>> rtl/gae_pkg.sv
package gae_pkg;
   localparam int MODE_W   = 2;
   localparam int SYM_W    = 5;
   localparam int ENTRY_W  = 8;
   localparam int GAP_W    = 8;
   localparam int SCORE_W  = 15;
   localparam int KIND_W   = 2;
   localparam int COLW_W   = KIND_W + 2 * SYM_W;

   localparam logic [GAP_W-1:0] GAP_RESET = 8'hFB;

   localparam logic [MODE_W-1:0] MODE_SCORE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APP_A = 2'd1;
   localparam logic [MODE_W-1:0] MODE_APP_B = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ALIGN = 2'd3;

   localparam logic [KIND_W-1:0] KIND_MATCH = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GAP_A = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GAP_B = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_EMPTY, ST_INIT_COL, ST_INIT_ROW,
      ST_C_RD, ST_C_TB, ST_C_WR,
      ST_TB_CUR, ST_TB_LEFT, ST_TB_UP, ST_TB_DEC,
      ST_EM_RD, ST_EM_LD
   } state_type;
endpackage

>>> rtl/gae_ram.sv
module gae_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
   output logic [WIDTH-1:0]                             rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/global_alignment_engine.sv
// Channel | Dir | Ports                                          | Beat
// req     | in  | req_mode/row_code/col_code/entry_score         | one command
// rsp     | out | rsp_column_kind/a_symbol/b_symbol/total_score  | one column
//         |     | rsp_last_column                                |
// csr     | in  | csr_gap_penalty                                | one register write
// Align with lengths la, lb: about (la+lb+1) init writes, then the fill steps
// through ST_C_RD, ST_C_TB, ST_C_WR per cell (one matrix port read per cell); each
// traceback column steps ST_TB_CUR, ST_TB_LEFT, ST_TB_UP, ST_TB_DEC, each output
// column ST_EM_RD, ST_EM_LD. Reset sweeps the score table to zero, req_ready low.
// A finished column waits in the output register; after the last column the next command is taken meanwhile.
module global_alignment_engine #(
   parameter int MAX_LEN      = 32,
   parameter int SYMBOL_COUNT = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gae_pkg::MODE_W-1:0]      req_mode,
   input  logic [gae_pkg::SYM_W-1:0]       req_row_code,
   input  logic [gae_pkg::SYM_W-1:0]       req_col_code,
   input  logic signed [gae_pkg::ENTRY_W-1:0] req_entry_score,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gae_pkg::KIND_W-1:0]      rsp_column_kind,
   output logic [gae_pkg::SYM_W-1:0]       rsp_a_symbol,
   output logic [gae_pkg::SYM_W-1:0]       rsp_b_symbol,
   output logic signed [gae_pkg::SCORE_W-1:0] rsp_total_score,
   output logic                            rsp_last_column,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic signed [gae_pkg::GAP_W-1:0] csr_gap_penalty
);
   import gae_pkg::*;
   `include "global_alignment_engine_assert.svh"

   localparam int DIM  = MAX_LEN + 1;
   localparam int LW   = $clog2(MAX_LEN + 1);
   localparam int AW   = MAX_LEN > 1 ? $clog2(MAX_LEN) : 1;
   localparam int TDEP = SYMBOL_COUNT * SYMBOL_COUNT;
   localparam int TW   = $clog2(TDEP);
   localparam int DDEP = DIM * DIM;
   localparam int DW   = $clog2(DDEP);
   localparam int CDEP = 2 * MAX_LEN;
   localparam int CW   = $clog2(CDEP);
   localparam int SW   = SCORE_W + 1;

   state_type state_ff, state_in;
   logic [LW-1:0] i_ff, i_in, j_ff, j_in, len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [CW:0] n_ff, n_in, k_ff, k_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic signed [SCORE_W-1:0] acc_ff, acc_in, left_ff, left_in, diag_ff, diag_in;
   logic signed [SCORE_W-1:0] cur_ff, cur_in, total_ff, total_in;
   logic signed [GAP_W-1:0] gap_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [SYM_W-1:0] asym_ff, asym_in, bsym_ff, bsym_in;
   logic signed [SCORE_W-1:0] oscore_ff, oscore_in;
   logic last_ff, last_in;

   logic tbl_we, dp_we, sa_we, sb_we, cb_we;
   logic [TW-1:0] tbl_waddr, tbl_raddr;
   logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
   logic [DW-1:0] dp_waddr, dp_raddr;
   logic [SCORE_W-1:0] dp_wdata, dp_rdata;
   logic [AW-1:0] sa_waddr, sb_waddr, sa_raddr, sb_raddr;
   logic [SYM_W-1:0] sa_rdata, sb_rdata;
   logic [CW-1:0] cb_waddr, cb_raddr;
   logic [COLW_W-1:0] cb_wdata, cb_rdata;

   logic accept, out_free, pair_ok, req_ok;
   logic signed [SCORE_W-1:0] gap15, best15;
   logic signed [SW-1:0] gap16, up16, left16, diag16, best16, cur16, pscore16;

   function automatic logic [DW-1:0] dpa(input logic [LW-1:0] ri, input logic [LW-1:0] cj);
      dpa = DW'(ri) * DW'(DIM) + DW'(cj);
   endfunction

   gae_ram #(.WIDTH(ENTRY_W), .DEPTH(TDEP)) u_tbl (
      .clock, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
      .raddr(tbl_raddr), .rdata(tbl_rdata));
   gae_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seqa (
      .clock, .we(sa_we), .waddr(sa_waddr), .wdata(req_row_code),
      .raddr(sa_raddr), .rdata(sa_rdata));
   gae_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_seqb (
      .clock, .we(sb_we), .waddr(sb_waddr), .wdata(req_row_code),
      .raddr(sb_raddr), .rdata(sb_rdata));
   gae_ram #(.WIDTH(SCORE_W), .DEPTH(DDEP)) u_dp (
      .clock, .we(dp_we), .waddr(dp_waddr), .wdata(dp_wdata),
      .raddr(dp_raddr), .rdata(dp_rdata));
   gae_ram #(.WIDTH(COLW_W), .DEPTH(CDEP)) u_cbuf (
      .clock, .we(cb_we), .waddr(cb_waddr), .wdata(cb_wdata),
      .raddr(cb_raddr), .rdata(cb_rdata));

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign gap15 = SCORE_W'(gap_ff);
   assign gap16 = SW'(gap_ff);
   assign sa_raddr = AW'(i_ff - 1'b1);
   assign sb_raddr = AW'(j_ff - 1'b1);
   assign sa_waddr = AW'(len_a_ff);
   assign sb_waddr = AW'(len_b_ff);
   assign tbl_raddr = TW'(sa_rdata) * TW'(SYMBOL_COUNT) + TW'(sb_rdata);
   assign pair_ok = ({1'b0, sa_rdata} < (SYM_W + 1)'(SYMBOL_COUNT))
                 && ({1'b0, sb_rdata} < (SYM_W + 1)'(SYMBOL_COUNT));
   assign req_ok  = ({1'b0, req_row_code} < (SYM_W + 1)'(SYMBOL_COUNT))
                 && ({1'b0, req_col_code} < (SYM_W + 1)'(SYMBOL_COUNT));
   assign pscore16 = pair_ok ? SW'($signed(tbl_rdata)) : '0;
   assign up16   = SW'($signed(dp_rdata)) + gap16;
   assign left16 = SW'(left_ff) + gap16;
   assign diag16 = SW'(diag_ff) + pscore16;
   assign best16 = (up16 > left16) ? ((up16 > diag16) ? up16 : diag16)
                                   : ((left16 > diag16) ? left16 : diag16);
   assign best15 = SCORE_W'(best16);
   assign cur16  = SW'(cur_ff);
   assign cb_raddr = CW'(n_ff - k_ff - 1'b1);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff; j_in = j_ff; n_in = n_ff; k_in = k_ff; clr_in = clr_ff;
      len_a_in = len_a_ff; len_b_in = len_b_ff;
      acc_in = acc_ff; left_in = left_ff; diag_in = diag_ff;
      cur_in = cur_ff; total_in = total_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      kind_in = kind_ff; asym_in = asym_ff; bsym_in = bsym_ff;
      oscore_in = oscore_ff; last_in = last_ff;
      tbl_we = 1'b0; tbl_waddr = TW'(req_row_code) * TW'(SYMBOL_COUNT) + TW'(req_col_code);
      tbl_wdata = req_entry_score;
      sa_we = 1'b0; sb_we = 1'b0;
      dp_we = 1'b0; dp_waddr = dpa(i_ff, j_ff); dp_wdata = acc_ff;
      dp_raddr = dpa(LW'(i_ff - 1'b1), j_ff);
      cb_we = 1'b0; cb_waddr = CW'(n_ff); cb_wdata = '0;
      case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1; tbl_waddr = clr_ff; tbl_wdata = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == TW'(TDEP - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_mode)
                  MODE_SCORE: tbl_we = req_ok;
                  MODE_APP_A: begin
                     if (len_a_ff < LW'(MAX_LEN)) begin
                        sa_we = 1'b1; len_a_in = len_a_ff + 1'b1;
                     end
                  end
                  MODE_APP_B: begin
                     if (len_b_ff < LW'(MAX_LEN)) begin
                        sb_we = 1'b1; len_b_in = len_b_ff + 1'b1;
                     end
                  end
                  default: begin
                     if (len_a_ff == '0 && len_b_ff == '0) begin
                        state_in = ST_EMPTY;
                     end else begin
                        i_in = '0; acc_in = '0; state_in = ST_INIT_COL;
                     end
                  end
               endcase
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1; kind_in = KIND_EMPTY; asym_in = '0; bsym_in = '0;
               oscore_in = '0; last_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_INIT_COL, ST_INIT_ROW: begin
            dp_we = 1'b1;
            dp_waddr = (state_ff == ST_INIT_COL) ? dpa(i_ff, '0) : dpa('0, j_ff);
            acc_in = acc_ff + gap15;
            if (state_ff == ST_INIT_COL && i_ff != len_a_ff) begin
               i_in = i_ff + 1'b1;
            end else if (state_ff == ST_INIT_COL && len_b_ff != '0) begin
               j_in = LW'(1); acc_in = gap15; state_in = ST_INIT_ROW;
            end else if (state_ff == ST_INIT_ROW && j_ff != len_b_ff) begin
               j_in = j_ff + 1'b1;
            end else if (len_a_ff != '0 && len_b_ff != '0) begin
               // start the fill at cell (1,1); acc holds the row's edge value
               i_in = LW'(1); j_in = LW'(1);
               acc_in = gap15; left_in = gap15; diag_in = '0;
               state_in = ST_C_RD;
            end else begin
               i_in = len_a_ff; j_in = len_b_ff; n_in = '0; state_in = ST_TB_CUR;
            end
         end
         ST_C_RD: state_in = ST_C_TB;
         ST_C_TB: state_in = ST_C_WR;
         ST_C_WR: begin
            dp_we = 1'b1; dp_waddr = dpa(i_ff, j_ff); dp_wdata = best15;
            left_in = best15; diag_in = dp_rdata;
            state_in = ST_C_RD;
            if (j_ff != len_b_ff) begin
               j_in = j_ff + 1'b1;
            end else if (i_ff != len_a_ff) begin
               i_in = i_ff + 1'b1; j_in = LW'(1);
               acc_in = acc_ff + gap15; left_in = acc_ff + gap15; diag_in = acc_ff;
            end else begin
               n_in = '0; state_in = ST_TB_CUR;
            end
         end
         ST_TB_CUR: begin
            dp_raddr = dpa(i_ff, j_ff);
            if (i_ff == '0 && j_ff == '0) begin
               k_in = '0; state_in = ST_EM_RD;
            end else begin
               state_in = ST_TB_LEFT;
            end
         end
         ST_TB_LEFT: begin
            dp_raddr = dpa(i_ff, LW'(j_ff - 1'b1));
            cur_in = dp_rdata;
            if (n_ff == '0) total_in = dp_rdata;
            state_in = ST_TB_UP;
         end
         ST_TB_UP: begin
            left_in = dp_rdata;
            state_in = ST_TB_DEC;
         end
         ST_TB_DEC: begin
            cb_we = 1'b1; n_in = n_ff + 1'b1; state_in = ST_TB_CUR;
            // tie order: gap in A, then gap in B, then diagonal
            if (j_ff != '0 && (i_ff == '0 || cur16 == left16)) begin
               cb_wdata = {KIND_GAP_A, {SYM_W{1'b0}}, sb_rdata};
               j_in = j_ff - 1'b1;
            end else if (i_ff != '0 && (j_ff == '0 || cur16 == up16)) begin
               cb_wdata = {KIND_GAP_B, sa_rdata, {SYM_W{1'b0}}};
               i_in = i_ff - 1'b1;
            end else begin
               cb_wdata = {KIND_MATCH, sa_rdata, sb_rdata};
               i_in = i_ff - 1'b1; j_in = j_ff - 1'b1;
            end
         end
         ST_EM_RD: state_in = ST_EM_LD;
         ST_EM_LD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in = cb_rdata[COLW_W-1 -: KIND_W];
               asym_in = cb_rdata[2*SYM_W-1 -: SYM_W];
               bsym_in = cb_rdata[SYM_W-1:0];
               oscore_in = total_ff;
               last_in = (k_ff + 1'b1 == n_ff);
               if (k_ff + 1'b1 == n_ff) begin
                  len_a_in = '0; len_b_in = '0; state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1; state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         len_a_ff <= '0;
         len_b_ff <= '0;
         n_ff <= '0;
         rsp_valid_ff <= 1'b0;
         gap_ff <= GAP_RESET;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         len_a_ff <= len_a_in;
         len_b_ff <= len_b_in;
         n_ff <= n_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) gap_ff <= csr_gap_penalty;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
      acc_ff <= acc_in; left_ff <= left_in; diag_ff <= diag_in;
      cur_ff <= cur_in; total_ff <= total_in;
      kind_ff <= kind_in; asym_ff <= asym_in; bsym_ff <= bsym_in;
      oscore_ff <= oscore_in; last_ff <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column_kind = kind_ff;
   assign rsp_a_symbol    = asym_ff;
   assign rsp_b_symbol    = bsym_ff;
   assign rsp_total_score = oscore_ff;
   assign rsp_last_column = last_ff;

   `GAE_NEVER(a_col_count, clock, reset, n_ff > (CW + 1)'(CDEP), "column count overflow")
   `GAE_ASSERT(a_tb_bounds, clock, reset,
      (state_ff == ST_TB_CUR) |-> (i_ff <= len_a_ff && j_ff <= len_b_ff),
      "traceback index out of range")
   `GAE_ASSERT(a_last_idle, clock, reset,
      (state_ff == ST_EM_LD && out_free && k_ff + 1'b1 == n_ff)
         |=> (state_ff == ST_IDLE && len_a_ff == '0 && len_b_ff == '0),
      "run did not close after last column")
   `GAE_ASSERT(a_fill_edge, clock, reset,
      (state_ff == ST_C_WR) |-> (i_ff != '0 && j_ff != '0),
      "fill touched the matrix edge")
endmodule
